>>> rtl/mcs_pkg.sv
// Shared constants and types for the maximum clique search block.
package mcs_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(51);
  localparam logic [CNT_W-1:0] MAX_CNT      = CNT_W'(MAX_VERTICES);

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic             en;
    logic [VTX_W-1:0] row;
    logic [VTX_W-1:0] column;
    logic             edge_present;
  } adj_wr_t;

  typedef struct packed {
    logic             include_ok;
    logic             better;
    logic             bound_ok;
    logic [CNT_W-1:0] size_adj;
  } step_status_t;

endpackage

>>> rtl/max_clique_search.sv
// Top level of the maximum clique search block: stream ports, config and result register.
//
//   Channel   Direction  Accepted when                Carries
//   s_axis    in         s_axis_tvalid & tready       tuser: mode; tdata: row, column, edge
//   m_axis    out        m_axis_tvalid & tready       tdata: best_members, best_size
//   cfg       in         cfg_valid & cfg_ready        cfg_data_i: vertex_count
//
// An adjacency write request is written into the memory as it is accepted. A search request
// steps down into a depth through an adjacency memory read, then evaluation, and steps back up
// through evaluation alone, then hands off once the output register is free; the number of steps
// depends on the graph and can grow exponentially with the vertex count. The single adjacency read
// port and the shared step unit set its pace. s_axis_tready is low while a search runs.
// Reset clears the adjacency matrix through per-row valid bits; no clearing pass is needed.
// A finished result waits in the output register while new requests are accepted.
module max_clique_search (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [15:0]               s_axis_tdata,  // row[5:0], column[11:6], edge_present[12]
  input  logic                      s_axis_tuser,  // mode[0]
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [71:0]               m_axis_tdata,  // best_members[63:0], best_size[70:64]
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mcs_pkg::CNT_W-1:0] cfg_data_i
);
  import mcs_pkg::*;

  logic [CNT_W-1:0]        vcount_q;
  logic                    in_acc;
  adj_wr_t                 adj_wr;
  logic                    rd_en;
  logic [VTX_W-1:0]        rd_addr;
  logic [MAX_VERTICES-1:0] adj_row;
  logic                    idle;
  logic                    res_valid;
  logic [MAX_VERTICES-1:0] res_members;
  logic [CNT_W-1:0]        res_size;
  logic                    out_free;
  logic                    out_vld_q;
  logic [71:0]             out_data_q;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = idle;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  always_comb begin
    adj_wr.en           = in_acc && (s_axis_tuser == MODE_WRITE);
    adj_wr.row          = s_axis_tdata[5:0];
    adj_wr.column       = s_axis_tdata[11:6];
    adj_wr.edge_present = s_axis_tdata[12];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vcount_q <= cfg_data_i;
    end
  end

  mcs_adj_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (adj_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (adj_row)
  );

  mcs_search_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_acc && (s_axis_tuser == MODE_SEARCH)),
    .vcount_i      (vcount_q),
    .out_free_i    (out_free),
    .adj_row_i     (adj_row),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .idle_o        (idle),
    .res_valid_o   (res_valid),
    .res_members_o (res_members),
    .res_size_o    (res_size)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= {1'b0, res_size, res_members};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> rtl/mcs_adj_mem.sv
// Adjacency bit matrix memory with per-row valid bits and a registered read port.
module mcs_adj_mem (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mcs_pkg::adj_wr_t                    wr_i,
  input  logic                                rd_en_i,
  input  logic [mcs_pkg::VTX_W-1:0]           rd_addr_i,
  output logic [mcs_pkg::MAX_VERTICES-1:0]    rd_data_o
);
  import mcs_pkg::*;

  logic [MAX_VERTICES-1:0] mem_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld_q;
  logic [MAX_VERTICES-1:0] rd_data_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      if (row_vld_q[wr_i.row]) begin
        mem_q[wr_i.row][wr_i.column] <= wr_i.edge_present;
      end else begin
        mem_q[wr_i.row] <= wr_i.edge_present ?
                           (MAX_VERTICES'(1) << wr_i.column) : '0;
      end
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_i.en) begin
        row_vld_q[wr_i.row] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

>>> rtl/mcs_step_unit.sv
// Shared evaluation unit: adjacency check, size adjust, bound and leaf compares.
module mcs_step_unit (
  input  logic [mcs_pkg::MAX_VERTICES-1:0] cur_set_i,
  input  logic [mcs_pkg::MAX_VERTICES-1:0] adj_row_i,
  input  logic [mcs_pkg::CNT_W-1:0]        size_i,
  input  logic [mcs_pkg::CNT_W-1:0]        best_cnt_i,
  input  logic [mcs_pkg::CNT_W-1:0]        depth_i,
  input  logic [mcs_pkg::CNT_W-1:0]        n_i,
  input  logic                             dec_i,
  output mcs_pkg::step_status_t            status_o
);
  import mcs_pkg::*;

  logic [CNT_W:0] bound_sum;

  always_comb begin
    status_o.include_ok = ((cur_set_i & ~adj_row_i) == '0);
    status_o.better     = (size_i > best_cnt_i);
    status_o.size_adj   = dec_i ? (size_i - CNT_W'(1)) : size_i;
    bound_sum = {1'b0, status_o.size_adj} + {1'b0, n_i} - {1'b0, depth_i}
                - (CNT_W+1)'(1);
    status_o.bound_ok   = (bound_sum > {1'b0, best_cnt_i});
  end

endmodule

>>> rtl/mcs_search_ctrl.sv
// Depth-first branch-and-bound sequencer around the shared step unit.
module mcs_search_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [mcs_pkg::CNT_W-1:0]        vcount_i,
  input  logic                             out_free_i,
  input  logic [mcs_pkg::MAX_VERTICES-1:0] adj_row_i,
  output logic                             rd_en_o,
  output logic [mcs_pkg::VTX_W-1:0]        rd_addr_o,
  output logic                             idle_o,
  output logic                             res_valid_o,
  output logic [mcs_pkg::MAX_VERTICES-1:0] res_members_o,
  output logic [mcs_pkg::CNT_W-1:0]        res_size_o
);
  import mcs_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_STEP  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [CNT_W-1:0]        depth_q, depth_d;
  logic                    enter_q, enter_d;
  logic [MAX_VERTICES-1:0] cur_q, cur_d;
  logic [CNT_W-1:0]        size_q, size_d;
  logic [MAX_VERTICES-1:0] best_q, best_d;
  logic [CNT_W-1:0]        bcnt_q, bcnt_d;
  logic [CNT_W-1:0]        n_q, n_d;

  logic [MAX_VERTICES-1:0] depth_bit;
  logic                    cur_bit;
  step_status_t            st;

  assign depth_bit = MAX_VERTICES'(1) << depth_q[VTX_W-1:0];
  assign cur_bit   = cur_q[depth_q[VTX_W-1:0]];

  mcs_step_unit u_step (
    .cur_set_i  (cur_q),
    .adj_row_i  (adj_row_i),
    .size_i     (size_q),
    .best_cnt_i (bcnt_q),
    .depth_i    (depth_q),
    .n_i        (n_q),
    .dec_i      (!enter_q && cur_bit),
    .status_o   (st)
  );

  always_comb begin
    logic up;
    up      = 1'b0;
    state_d = state_q;
    depth_d = depth_q;
    enter_d = enter_q;
    cur_d   = cur_q;
    size_d  = size_q;
    best_d  = best_q;
    bcnt_d  = bcnt_q;
    n_d     = n_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cur_d   = '0;
          size_d  = '0;
          best_d  = '0;
          bcnt_d  = '0;
          depth_d = '0;
          enter_d = 1'b1;
          n_d     = (vcount_i > MAX_CNT) ? MAX_CNT : vcount_i;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_STEP;
      end
      S_STEP: begin
        if (depth_q >= n_q) begin
          if (st.better) begin
            best_d = cur_q;
            bcnt_d = size_q;
          end
          up = 1'b1;
        end else if (enter_q && st.include_ok) begin
          cur_d   = cur_q | depth_bit;
          size_d  = size_q + CNT_W'(1);
          depth_d = depth_q + CNT_W'(1);
          state_d = S_FETCH;
        end else if (!enter_q && !cur_bit) begin
          up = 1'b1;
        end else begin
          cur_d  = cur_q & ~depth_bit;
          size_d = st.size_adj;
          if (st.bound_ok) begin
            depth_d = depth_q + CNT_W'(1);
            enter_d = 1'b1;
            state_d = S_FETCH;
          end else begin
            up = 1'b1;
          end
        end
        if (up) begin
          if (depth_q == '0) begin
            state_d = S_DONE;
          end else begin
            depth_d = depth_q - CNT_W'(1);
            enter_d = 1'b0;
          end
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      depth_q <= '0;
      enter_q <= 1'b0;
      size_q  <= '0;
      bcnt_q  <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      enter_q <= enter_d;
      size_q  <= size_d;
      bcnt_q  <= bcnt_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    best_q <= best_d;
  end

  assign rd_en_o       = (state_q == S_FETCH);
  assign rd_addr_o     = depth_q[VTX_W-1:0];
  assign idle_o        = (state_q == S_IDLE);
  assign res_valid_o   = (state_q == S_DONE) && out_free_i;
  assign res_members_o = best_q;
  assign res_size_o    = bcnt_q;

endmodule
